// ===== design/fwrc_pkg.sv =====
// Shared types and constants for the message queue with remove by code.
package fwrc_pkg;

  localparam int WORD_W     = 32;
  localparam int KIND_W     = 2;
  localparam int IN_DATA_W  = 4 * WORD_W;
  localparam int OUT_DATA_W = 3 * WORD_W;
  localparam int OUT_USER_W = 2;

  localparam logic [KIND_W-1:0] KIND_ENQ = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DEQ = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RM  = 2'd2;

  typedef struct packed {
    logic [WORD_W-1:0] code;
    logic [WORD_W-1:0] first_arg;
    logic [WORD_W-1:0] second_arg;
  } msg_t;

  typedef struct packed {
    logic enq;
    logic res_zero;
    logic deq_read;
    logic deq_pop;
    logic rm_start;
    logic rm_run;
    logic rm_finish;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic rm_idle;
    logic out_free;
  } sts_t;

endpackage

// ===== design/fwrc_ctrl.sv =====
// Controller state machine for the message queue.
module fwrc_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [fwrc_pkg::KIND_W-1:0] in_kind,
  input  fwrc_pkg::sts_t              sts,
  output fwrc_pkg::cmd_t              cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DEQ  = 2'd1;
  localparam logic [1:0] ST_RM   = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       accept;

  assign in_tready = (state_r == ST_IDLE) && sts.out_free;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_kind)
            fwrc_pkg::KIND_ENQ: begin
              if (sts.full) begin
                cmd.res_zero = 1'b1;
              end else begin
                cmd.enq = 1'b1;
              end
            end
            fwrc_pkg::KIND_DEQ: begin
              if (sts.empty) begin
                cmd.res_zero = 1'b1;
              end else begin
                cmd.deq_read = 1'b1;
                state_nxt    = ST_DEQ;
              end
            end
            fwrc_pkg::KIND_RM: begin
              cmd.rm_start = 1'b1;
              state_nxt    = ST_RM;
            end
            default: begin
              cmd.res_zero = 1'b1;
            end
          endcase
        end
      end
      ST_DEQ: begin
        cmd.deq_pop = 1'b1;
        state_nxt   = ST_IDLE;
      end
      ST_RM: begin
        if (sts.rm_idle) begin
          cmd.rm_finish = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          cmd.rm_run = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_deq_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DEQ) |=> (state_r == ST_IDLE))
    else $error("dequeue read did not return to idle");

  a_rm_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_kind == fwrc_pkg::KIND_RM) |=> (state_r == ST_RM))
    else $error("remove item did not start the walk");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_tready)
    else $error("ready raised while an item is in progress");

endmodule

// ===== design/fwrc_dpath.sv =====
// Datapath for the message queue: store, pointers, remove walk and result register.
module fwrc_dpath #(
  parameter int DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  fwrc_pkg::cmd_t                  cmd,
  output fwrc_pkg::sts_t                  sts,
  input  logic [fwrc_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [fwrc_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [fwrc_pkg::OUT_USER_W-1:0] out_tuser
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int WW = fwrc_pkg::WORD_W;

  fwrc_pkg::msg_t mem [DEPTH];
  fwrc_pkg::msg_t rd_data_r;
  fwrc_pkg::msg_t in_msg;
  fwrc_pkg::msg_t wr_data;
  logic [AW-1:0]  wr_addr;
  logic [AW-1:0]  rd_addr;
  logic           wr_en;
  logic           rd_en;

  logic [AW-1:0]  head_r;
  logic [AW-1:0]  head_nxt;
  logic [CW-1:0]  occ_r;
  logic [CW-1:0]  occ_nxt;
  logic [CW-1:0]  rd_cnt_r;
  logic [CW-1:0]  rd_cnt_nxt;
  logic [CW-1:0]  kept_r;
  logic [CW-1:0]  kept_nxt;
  logic           proc_valid_r;
  logic           proc_valid_nxt;
  logic [WW-1:0]  match_r;
  logic [WW-1:0]  match_nxt;

  logic           out_valid_r;
  logic           out_valid_nxt;
  logic           out_acc_r;
  logic           out_acc_nxt;
  logic           out_has_r;
  logic           out_has_nxt;
  fwrc_pkg::msg_t out_msg_r;
  fwrc_pkg::msg_t out_msg_nxt;
  logic           out_load;
  logic           rd_more;
  logic           keep_cur;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [CW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + (AW+1)'(off);
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign in_msg.code       = in_tdata[WW-1:0];
  assign in_msg.first_arg  = in_tdata[2*WW-1:WW];
  assign in_msg.second_arg = in_tdata[3*WW-1:2*WW];

  assign rd_more  = (rd_cnt_r != occ_r);
  assign keep_cur = proc_valid_r && (rd_data_r.code != match_r);
  assign out_load = cmd.enq || cmd.res_zero || cmd.deq_pop || cmd.rm_finish;

  assign sts.full     = (occ_r == CW'(DEPTH));
  assign sts.empty    = (occ_r == '0);
  assign sts.rm_idle  = !rd_more && !proc_valid_r;
  assign sts.out_free = !out_valid_r || out_tready;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = slot_of(head_r, occ_r);
    wr_data = in_msg;
    rd_en   = 1'b0;
    rd_addr = head_r;
    if (cmd.enq) begin
      wr_en = 1'b1;
    end
    if (cmd.rm_run && keep_cur) begin
      wr_en   = 1'b1;
      wr_addr = slot_of(head_r, kept_r);
      wr_data = rd_data_r;
    end
    if (cmd.deq_read) begin
      rd_en = 1'b1;
    end
    if (cmd.rm_run && rd_more) begin
      rd_en   = 1'b1;
      rd_addr = slot_of(head_r, rd_cnt_r);
    end
  end

  always_comb begin
    head_nxt       = head_r;
    occ_nxt        = occ_r;
    rd_cnt_nxt     = rd_cnt_r;
    kept_nxt       = kept_r;
    proc_valid_nxt = proc_valid_r;
    match_nxt      = match_r;
    if (cmd.enq) begin
      occ_nxt = occ_r + CW'(1);
    end
    if (cmd.deq_pop) begin
      head_nxt = slot_of(head_r, CW'(1));
      occ_nxt  = occ_r - CW'(1);
    end
    if (cmd.rm_start) begin
      rd_cnt_nxt     = '0;
      kept_nxt       = '0;
      proc_valid_nxt = 1'b0;
      match_nxt      = in_tdata[4*WW-1:3*WW];
    end
    if (cmd.rm_run) begin
      proc_valid_nxt = rd_more;
      if (rd_more) begin
        rd_cnt_nxt = rd_cnt_r + CW'(1);
      end
      if (keep_cur) begin
        kept_nxt = kept_r + CW'(1);
      end
    end
    if (cmd.rm_finish) begin
      occ_nxt = kept_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_acc_nxt   = out_acc_r;
    out_has_nxt   = out_has_r;
    out_msg_nxt   = out_msg_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_acc_nxt   = cmd.enq;
      out_has_nxt   = cmd.deq_pop;
      out_msg_nxt   = cmd.deq_pop ? rd_data_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r       <= '0;
      occ_r        <= '0;
      rd_cnt_r     <= '0;
      kept_r       <= '0;
      proc_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      head_r       <= head_nxt;
      occ_r        <= occ_nxt;
      rd_cnt_r     <= rd_cnt_nxt;
      kept_r       <= kept_nxt;
      proc_valid_r <= proc_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    match_r   <= match_nxt;
    out_acc_r <= out_acc_nxt;
    out_has_r <= out_has_nxt;
    out_msg_r <= out_msg_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_msg_r.second_arg, out_msg_r.first_arg, out_msg_r.code};
  assign out_tuser  = {out_has_r, out_acc_r};

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CW'(DEPTH))
    else $error("occupancy beyond depth");

  a_kept_bound: assert property (@(posedge clk) disable iff (!rst_n)
    kept_r <= rd_cnt_r)
    else $error("compaction write pointer passed read pointer");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_tready))
    else $error("result register loaded while still held");

  a_rm_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rm_finish |=> (occ_r <= $past(occ_r)))
    else $error("remove grew the queue");

endmodule

// ===== design/fifo_with_remove_by_code.sv =====
// Top level: ordered message queue with enqueue, dequeue and remove by code.
//
//  channel  ports           payload
//  input    in_t*           tuser: kind; tdata: msg_code, msg_first_arg, msg_second_arg,
//                           match_code
//  result   out_t*          tuser: accepted, has_message; tdata: out_code, out_first_arg,
//                           out_second_arg
//
// Enqueue, no-op and empty dequeue load the result register directly; a dequeue that
// returns a message first reads the store through its registered read, then loads the result.
// Remove walks the queue with the single read port, one entry a cycle, then checks
// the last entry read and loads the result; on an empty queue there is nothing to walk.
// Reset clears head, occupancy and control; store contents need no clearing.
// A result waits in the output register; the next item is taken once it leaves.
module fifo_with_remove_by_code #(
  parameter int DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [fwrc_pkg::IN_DATA_W-1:0]  in_tdata,   // msg_code, msg_first_arg,
                                                      // msg_second_arg, match_code
  input  logic [fwrc_pkg::KIND_W-1:0]     in_tuser,   // kind
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [fwrc_pkg::OUT_DATA_W-1:0] out_tdata,  // out_code, out_first_arg,
                                                      // out_second_arg
  output logic [fwrc_pkg::OUT_USER_W-1:0] out_tuser   // accepted, has_message
);

  fwrc_pkg::cmd_t cmd;
  fwrc_pkg::sts_t sts;

  fwrc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_kind   (in_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  fwrc_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== bench/tb_fifo_with_remove_by_code.sv =====
// Self-checking testbench for the message queue with enqueue, dequeue and remove by code.
module tb_fifo_with_remove_by_code;

  localparam int WW             = fwrc_pkg::WORD_W;
  localparam int QUEUE_DEPTH    = 16;
  localparam int LONG_STALL     = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;
  localparam logic [fwrc_pkg::KIND_W-1:0] KIND_NOP = 2'd3;

  typedef struct packed {
    logic          accepted;
    logic          has_message;
    logic [WW-1:0] code;
    logic [WW-1:0] first_arg;
    logic [WW-1:0] second_arg;
  } reply_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [fwrc_pkg::IN_DATA_W-1:0]  in_tdata;
  logic [fwrc_pkg::KIND_W-1:0]     in_tuser;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [fwrc_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [fwrc_pkg::OUT_USER_W-1:0] out_tuser;

  fwrc_pkg::msg_t queued_msgs[$];
  reply_t         expected_replies[$];
  int unsigned    error_count;
  int unsigned    idle_cycles;
  int unsigned    send_run;
  bit             no_idle;
  bit             long_stall_req;
  logic [WW-1:0]  code_pool[4];

  fifo_with_remove_by_code #(.DEPTH(QUEUE_DEPTH)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic reply_t apply_queue_op(input logic [fwrc_pkg::KIND_W-1:0] kind,
                                            input fwrc_pkg::msg_t msg,
                                            input logic [WW-1:0] match_code);
    reply_t         reply;
    fwrc_pkg::msg_t head_msg;
    fwrc_pkg::msg_t kept[$];
    reply = '0;
    case (kind)
      fwrc_pkg::KIND_ENQ: begin
        if (queued_msgs.size() < QUEUE_DEPTH) begin
          queued_msgs = {queued_msgs, msg};
          reply.accepted = 1'b1;
        end
      end
      fwrc_pkg::KIND_DEQ: begin
        if (queued_msgs.size() > 0) begin
          head_msg = queued_msgs[0];
          queued_msgs.delete(0);
          reply.has_message = 1'b1;
          reply.code        = head_msg.code;
          reply.first_arg   = head_msg.first_arg;
          reply.second_arg  = head_msg.second_arg;
        end
      end
      fwrc_pkg::KIND_RM: begin
        foreach (queued_msgs[i])
          if (queued_msgs[i].code != match_code) kept = {kept, queued_msgs[i]};
        queued_msgs = kept;
      end
      default: ;
    endcase
    return reply;
  endfunction

  task automatic send_item(input logic [fwrc_pkg::KIND_W-1:0] kind,
                           input logic [WW-1:0] code,
                           input logic [WW-1:0] first_arg,
                           input logic [WW-1:0] second_arg,
                           input logic [WW-1:0] match_code);
    int unsigned    gap;
    fwrc_pkg::msg_t msg;
    gap = 0;
    if (!no_idle) begin
      if (send_run == 0) begin
        if ($urandom_range(0, 2) == 0) gap = $urandom_range(1, 13);
        send_run = $urandom_range(1, 40);
      end else begin
        send_run--;
      end
    end
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {match_code, second_arg, first_arg, code};
    do @(posedge clk); while (!in_tready);
    msg.code       = code;
    msg.first_arg  = first_arg;
    msg.second_arg = second_arg;
    expected_replies = {expected_replies, apply_queue_op(kind, msg, match_code)};
  endtask

  task automatic check_field(input string name, input logic [WW-1:0] expected,
                             input logic [WW-1:0] actual);
    if (expected !== actual) begin
      $display("%0t: %s expected %h actual %h", $time, name, expected, actual);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    reply_t exp_reply;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected item expected none actual %h/%h", $time, out_tuser,
                 out_tdata);
        error_count++;
      end else begin
        exp_reply = expected_replies[0];
        expected_replies.delete(0);
        check_field("accepted", WW'(exp_reply.accepted), WW'(out_tuser[0]));
        check_field("has_message", WW'(exp_reply.has_message), WW'(out_tuser[1]));
        check_field("out_code", exp_reply.code, out_tdata[31:0]);
        check_field("out_first_arg", exp_reply.first_arg, out_tdata[63:32]);
        check_field("out_second_arg", exp_reply.second_arg, out_tdata[95:64]);
      end
    end
  end

  initial begin
    int unsigned stall_left;
    int unsigned run_left;
    stall_left = 0;
    run_left   = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        stall_left     = LONG_STALL;
      end else if (stall_left == 0 && run_left == 0 && !no_idle) begin
        if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 13);
        else run_left = $urandom_range(1, 40);
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (run_left > 0) run_left--;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_directed;
    logic [WW-1:0] extremes[4];
    logic [WW-1:0] code;
    extremes = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    send_item(fwrc_pkg::KIND_DEQ, '1, '1, '1, '1);
    send_item(fwrc_pkg::KIND_RM, '0, '0, '0, '0);
    send_item(KIND_NOP, '1, '1, '1, '1);
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (i < 4) code = extremes[i];
      else if (i % 2 == 0) code = 32'h5A5A_5A5A;
      else code = $urandom();
      send_item(fwrc_pkg::KIND_ENQ, code, ~code, {code[15:0], code[31:16]}, $urandom());
    end
    send_item(fwrc_pkg::KIND_ENQ, 32'h1234_5678, '1, '0, '0);
    send_item(fwrc_pkg::KIND_RM, $urandom(), $urandom(), $urandom(), 32'h5A5A_5A5A);
    send_item(fwrc_pkg::KIND_RM, '0, '0, '0, 32'h1234_5678);
    send_item(fwrc_pkg::KIND_DEQ, '0, '0, '0, '0);
    send_item(fwrc_pkg::KIND_RM, '0, '0, '0, 32'hFFFF_FFFF);
    send_item(fwrc_pkg::KIND_DEQ, '0, '0, '0, '0);
  endtask

  task automatic send_random_item(input int unsigned enq_pct);
    logic [fwrc_pkg::KIND_W-1:0] kind;
    logic [WW-1:0]               code;
    logic [WW-1:0]               match_code;
    int unsigned                 roll;
    roll = $urandom_range(0, 99);
    if (roll < enq_pct) kind = fwrc_pkg::KIND_ENQ;
    else if (roll < 96) kind = ($urandom_range(0, 3) == 0) ? fwrc_pkg::KIND_RM
                                                            : fwrc_pkg::KIND_DEQ;
    else kind = KIND_NOP;
    code       = ($urandom_range(0, 9) < 7) ? code_pool[$urandom_range(0, 3)] : $urandom();
    match_code = ($urandom_range(0, 3) < 3) ? code_pool[$urandom_range(0, 3)] : $urandom();
    send_item(kind, code, $urandom(), $urandom(), match_code);
  endtask

  task automatic run_random_block(input int unsigned count);
    int unsigned enq_pct;
    enq_pct = 50;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        enq_pct = $urandom_range(20, 75);
        foreach (code_pool[j]) code_pool[j] = $urandom();
      end
      send_random_item(enq_pct);
    end
  endtask

  task automatic test_random;
    run_random_block(620);
  endtask

  task automatic test_output_backpressure;
    long_stall_req = 1'b1;
    for (int i = 0; i < 30; i++) send_random_item(70);
  endtask

  task automatic test_no_idle_tail;
    no_idle = 1'b1;
    run_random_block(100);
  endtask

  initial begin
    error_count    = 0;
    idle_cycles    = 0;
    send_run       = 0;
    no_idle        = 1'b0;
    long_stall_req = 1'b0;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = KIND_NOP;
    foreach (code_pool[j]) code_pool[j] = $urandom();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random();
    test_output_backpressure();
    test_no_idle_tail();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/fwrc_pkg.sv
design/fwrc_ctrl.sv
design/fwrc_dpath.sv
design/fifo_with_remove_by_code.sv
bench/tb_fifo_with_remove_by_code.sv
